// ===== rtl/core/btwf_pkg.sv =====
`default_nettype none
package btwf_pkg;

  localparam logic [63:0] HI_WORD    = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] LOW_HALF   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] BLOCK_STEP = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [63:0] umin;
    logic [63:0] umax;
    logic [63:0] smin;
    logic [63:0] smax;
    logic [31:0] umin32;
    logic [31:0] umax32;
    logic [31:0] smin32;
    logic [31:0] smax32;
    logic [63:0] known_bits;
    logic [63:0] unknown_bits;
  } query_t;

  // one search task: 64-bit interval and 32-bit interval
  typedef struct packed {
    logic        en;
    logic [63:0] amin;
    logic [63:0] amax;
    logic [31:0] bmin;
    logic [31:0] bmax;
  } task_t;

  // one candidate probe: start point, ceiling and low-half window
  typedef struct packed {
    logic        en;
    logic [63:0] start;
    logic [63:0] ceil;
    logic [31:0] bmin;
    logic [31:0] bmax;
    logic        lift;
  } probe_t;

  function automatic logic [63:0] next_member(input logic [63:0] kv,
                                              input logic [63:0] km,
                                              input logic [63:0] z);
    logic [63:0] top;
    logic [63:0] d;
    logic [63:0] dk;
    logic [63:0] cm;
    logic [63:0] inc;
    top = kv | km;
    d   = z - kv;
    dk  = d & ~km;
    // mask of all bits at or below the highest set bit of dk
    cm = dk;
    cm = cm | (cm >> 1);
    cm = cm | (cm >> 2);
    cm = cm | (cm >> 4);
    cm = cm | (cm >> 8);
    cm = cm | (cm >> 16);
    cm = cm | (cm >> 32);
    inc = ((d | cm | ~km) + 64'd1) & km;
    if (z >= top) begin
      next_member = top;
    end else if (z < kv) begin
      next_member = kv;
    end else begin
      next_member = kv | inc;
    end
  endfunction

  function automatic logic [63:0] align_up(input logic [63:0] kv,
                                           input logic [63:0] km,
                                           input logic [63:0] w);
    if ((w & ~km) == kv) begin
      align_up = w;
    end else begin
      align_up = next_member(kv, km, w);
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/btwf_probe.sv =====
`default_nettype none
// two-stage probe: align, optional lift to bmin and realign, then check
module btwf_probe (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire btwf_pkg::probe_t   pin,
  input  wire logic [63:0]        kv,
  input  wire logic [63:0]        km,
  output logic                    hit,
  output logic [63:0]             val
);
  import btwf_pkg::*;

  logic [63:0] w1;
  logic [63:0] w1_fix;
  logic [63:0] w2;
  logic [63:0] w3;
  probe_t      p1;
  probe_t      p2;
  logic [63:0] kv1;
  logic [63:0] km1;

  always_ff @(posedge clk) begin
    if (adv) begin
      w1  <= align_up(kv, km, pin.start);
      p1  <= pin;
      kv1 <= kv;
      km1 <= km;
    end
  end

  always_comb begin
    w1_fix = w1;
    if (p1.lift && (w1[31:0] < p1.bmin)) begin
      w1_fix = {w1[63:32], p1.bmin};
    end
    w2 = p1.lift ? align_up(kv1, km1, w1_fix) : w1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w3 <= w2;
      p2 <= p1;
    end
  end

  always_comb begin
    hit = p2.en && (w3 <= p2.ceil) && (w3[31:0] >= p2.bmin) && (w3[31:0] <= p2.bmax);
    val = w3;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bounds_tnum_witness_finder.sv =====
`default_nettype none
// bounds_tnum_witness_finder
// finds a 64-bit value inside unsigned/signed 64-bit bounds, unsigned/signed
// bounds on the low 32 bits and a tristate number (known_bits, unknown_bits)
// channels: s_axis query beats in, m_axis result beats out, one result per query
// s_axis_tdata: umin, umax, smin, smax, umin32, umax32, smin32, smax32,
//   known_bits, unknown_bits from the lowest bit up (512 of the 576 bits)
// m_axis_tdata: found (bit 0), witness (bits 64:1), zero padded to 72 bits
// throughput: one query per cycle unless m_axis stalls; the pipeline is six register stages
// (input, range split, candidate setup, tristate align, lift/realign,
// check and pick into the output register)
// and all twelve probes (4 interval pairs x 3 blocks) run in parallel lanes
// reset clears all valid bits; no result beat is pending afterwards
// when m_axis_tready is low the whole pipeline holds, nothing is lost;
// s_axis_tready is low only when the output stage is full and stalled
module bounds_tnum_witness_finder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [575:0] s_axis_tdata,  // query fields, umin lowest
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata   // found, witness, zero pad
);
  import btwf_pkg::*;

  localparam int NP = 12;

  query_t q_in;
  assign q_in = query_t'({s_axis_tdata[63:0], s_axis_tdata[127:64],
                          s_axis_tdata[191:128], s_axis_tdata[255:192],
                          s_axis_tdata[287:256], s_axis_tdata[319:288],
                          s_axis_tdata[351:320], s_axis_tdata[383:352],
                          s_axis_tdata[447:384], s_axis_tdata[511:448]});

  logic adv;
  logic v0, v1, v2, v3, v4;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: split ranges into up to two 64-bit and two 32-bit intervals
  query_t      q0;
  task_t [1:0] a64;
  task_t [1:0] b32;
  logic [63:0] kv0, km0;

  always_comb begin
    logic        sn, xn;
    logic [63:0] lo, hi;
    logic [31:0] lo3, hi3;
    sn = q0.smin[63];
    xn = q0.smax[63];
    lo = (q0.umin > q0.smin) ? q0.umin : q0.smin;
    hi = (q0.umax < q0.smax) ? q0.umax : q0.smax;
    a64 = '0;
    if (!sn || xn) begin
      a64[0] = '{en: lo <= hi, amin: lo, amax: hi, bmin: '0, bmax: '0};
    end else begin
      a64[0] = '{en: q0.umin <= hi, amin: q0.umin, amax: hi, bmin: '0, bmax: '0};
      a64[1] = '{en: lo <= q0.umax, amin: lo, amax: q0.umax, bmin: '0, bmax: '0};
    end
    lo3 = (q0.umin32 > q0.smin32) ? q0.umin32 : q0.smin32;
    hi3 = (q0.umax32 < q0.smax32) ? q0.umax32 : q0.smax32;
    b32 = '0;
    if (!q0.smin32[31] || q0.smax32[31]) begin
      b32[0] = '{en: lo3 <= hi3, amin: '0, amax: '0, bmin: lo3, bmax: hi3};
    end else begin
      b32[0] = '{en: q0.umin32 <= hi3, amin: '0, amax: '0, bmin: q0.umin32, bmax: hi3};
      b32[1] = '{en: lo3 <= q0.umax32, amin: '0, amax: '0, bmin: lo3, bmax: q0.umax32};
    end
  end

  // stage 1 registers: interval pairs in model order
  task_t [3:0] t1;
  logic  [63:0] kv1, km1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q0 <= q_in;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          t1[i*2+j] <= '{en: a64[i].en && b32[j].en, amin: a64[i].amin,
                         amax: a64[i].amax, bmin: b32[j].bmin, bmax: b32[j].bmax};
        end
      end
      kv1 <= q0.known_bits;
      km1 <= q0.unknown_bits;
    end
  end
  assign kv0 = kv1;
  assign km0 = km1;

  // candidate setup: three probes per pair (left/single, middle, right)
  probe_t [NP-1:0] pr;
  always_comb begin
    logic [63:0] xh, yh;
    logic [31:0] alo, ahi, l, r;
    logic        base;
    for (int k = 0; k < 4; k++) begin
      xh   = t1[k].amin & HI_WORD;
      yh   = t1[k].amax & HI_WORD;
      alo  = t1[k].amin[31:0];
      ahi  = t1[k].amax[31:0];
      l    = (alo > t1[k].bmin) ? alo : t1[k].bmin;
      r    = (ahi < t1[k].bmax) ? ahi : t1[k].bmax;
      base = t1[k].en && ((kv0 | km0) >= t1[k].amin);
      pr[k*3] = '{en: 1'b0, start: xh | {32'd0, l}, ceil: xh | LOW_HALF,
                  bmin: t1[k].bmin, bmax: t1[k].bmax, lift: 1'b0};
      pr[k*3+1] = '{en: base && (xh != yh) && (xh + BLOCK_STEP < yh),
                    start: xh + BLOCK_STEP, ceil: yh - 64'd1,
                    bmin: t1[k].bmin, bmax: t1[k].bmax, lift: 1'b1};
      pr[k*3+2] = '{en: base && (xh != yh) && (t1[k].bmin <= r),
                    start: yh | {32'd0, t1[k].bmin}, ceil: t1[k].amax,
                    bmin: t1[k].bmin, bmax: t1[k].bmax, lift: 1'b0};
      if (xh == yh) begin
        pr[k*3].en   = base && (l <= r);
        pr[k*3].ceil = t1[k].amax;
      end else begin
        pr[k*3].en   = base && (l <= t1[k].bmax);
      end
    end
  end

  probe_t [NP-1:0] pr2;
  logic   [63:0]   kv2, km2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pr2 <= pr;
      kv2 <= kv1;
      km2 <= km1;
    end
  end

  logic [NP-1:0] hit;
  logic [63:0]   val [NP];
  for (genvar g = 0; g < NP; g++) begin : g_probe
    btwf_probe u_probe (
      .clk (clk),
      .adv (adv),
      .pin (pr2[g]),
      .kv  (kv2),
      .km  (km2),
      .hit (hit[g]),
      .val (val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
      v4 <= v3;
    end
  end

  // pick first hit in model order
  logic        found_c;
  logic [63:0] wit_c;
  always_comb begin
    found_c = 1'b0;
    wit_c   = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_c = 1'b1;
        wit_c   = val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {7'd0, wit_c, found_c};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == 64'd0)
    else $error("witness not zero when not found");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire
